// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cascade PID checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cpar_pkg.sv -----
// ----------------------------------------------------------------------------
// cpar_pkg
// Types and constants shared by the cascade angle/rate PID modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpar_pkg;

  // Default internal signal format: signed Q16.16 in 32 bits.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths of the ports.
  localparam int IO_W        = 32;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 3 * IO_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 2 * IO_W;

  // A gain product is formed from two partial products split at this bit.
  localparam int MUL_SPLIT = 24;

  // Angle fold constants in whole degrees.
  localparam int ANGLE_HALF_DEG = 180;
  localparam int ANGLE_FULL_DEG = 360;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER_KP     = 3'd0,
    CFG_OUTER_KI     = 3'd1,
    CFG_OUTER_KD     = 3'd2,
    CFG_INNER_KP     = 3'd3,
    CFG_INNER_KI     = 3'd4,
    CFG_INNER_KD     = 3'd5,
    CFG_OUTER_LIMITS = 3'd6,
    CFG_INNER_LIMITS = 3'd7
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INT,
    ST_MLO,
    ST_MHI,
    ST_TERM,
    ST_ACC,
    ST_FIN,
    ST_DONE
  } ctrl_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_INT,
    OP_MLO,
    OP_MHI,
    OP_TERM,
    OP_ACC,
    OP_FIN,
    OP_PUSH
  } dp_op_t;

  // Which loop is being worked on.
  typedef enum logic [0:0] {
    LOOP_OUTER,
    LOOP_INNER
  } loop_t;

  // Which gain term is being formed.
  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
    loop_t  loop;
    term_t  term;
  } dp_cmd_t;

endpackage

// ----- design/cpar_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpar_ctrl
// Sequencer for the cascade PID: steps both loops through error, integral,
// three gain terms on the shared multiplier and the output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output cpar_pkg::dp_cmd_t cmd
);

  cpar_pkg::ctrl_state_t state_r, state_nxt;
  cpar_pkg::loop_t       loop_r, loop_nxt;
  cpar_pkg::term_t       term_r, term_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // State and handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpar_pkg::ST_IDLE;
      loop_r      <= cpar_pkg::LOOP_OUTER;
      term_r      <= cpar_pkg::TERM_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loop_r      <= loop_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    loop_nxt      = loop_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = cpar_pkg::OP_NONE;
    cmd.loop      = loop_r;
    cmd.term      = term_r;
    unique case (state_r)
      cpar_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = cpar_pkg::OP_LOAD;
          loop_nxt  = cpar_pkg::LOOP_OUTER;
          state_nxt = cpar_pkg::ST_ERR;
        end
      end
      cpar_pkg::ST_ERR: begin
        cmd.op    = cpar_pkg::OP_ERR;
        state_nxt = cpar_pkg::ST_INT;
      end
      cpar_pkg::ST_INT: begin
        cmd.op    = cpar_pkg::OP_INT;
        term_nxt  = cpar_pkg::TERM_P;
        state_nxt = cpar_pkg::ST_MLO;
      end
      cpar_pkg::ST_MLO: begin
        cmd.op    = cpar_pkg::OP_MLO;
        state_nxt = cpar_pkg::ST_MHI;
      end
      cpar_pkg::ST_MHI: begin
        cmd.op    = cpar_pkg::OP_MHI;
        state_nxt = cpar_pkg::ST_TERM;
      end
      cpar_pkg::ST_TERM: begin
        cmd.op    = cpar_pkg::OP_TERM;
        state_nxt = cpar_pkg::ST_ACC;
      end
      cpar_pkg::ST_ACC: begin
        cmd.op = cpar_pkg::OP_ACC;
        unique case (term_r)
          cpar_pkg::TERM_P: begin
            term_nxt  = cpar_pkg::TERM_I;
            state_nxt = cpar_pkg::ST_MLO;
          end
          cpar_pkg::TERM_I: begin
            term_nxt  = cpar_pkg::TERM_D;
            state_nxt = cpar_pkg::ST_MLO;
          end
          cpar_pkg::TERM_D: state_nxt = cpar_pkg::ST_FIN;
          default:          state_nxt = cpar_pkg::ST_FIN;
        endcase
      end
      cpar_pkg::ST_FIN: begin
        cmd.op = cpar_pkg::OP_FIN;
        if (loop_r == cpar_pkg::LOOP_OUTER) begin
          loop_nxt  = cpar_pkg::LOOP_INNER;
          state_nxt = cpar_pkg::ST_ERR;
        end else begin
          state_nxt = cpar_pkg::ST_DONE;
        end
      end
      cpar_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          cmd.op        = cpar_pkg::OP_PUSH;
          out_valid_nxt = 1'b1;
          state_nxt     = cpar_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpar_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- design/cpar_datapath.sv -----
// ----------------------------------------------------------------------------
// cpar_datapath
// Registers, loop state and arithmetic of the cascade PID: error with angle
// fold, clamped integral, derivative, shared 25x24 gain multiplier,
// saturating sum and output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpar_datapath #(
  parameter int DATA_WIDTH = cpar_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cpar_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [cpar_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpar_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
  input  logic signed [cpar_pkg::IO_W-1:0]      angle_setpoint,
  input  logic signed [cpar_pkg::IO_W-1:0]      angle_measured,
  input  logic signed [cpar_pkg::IO_W-1:0]      rate_measured,
  input  logic                                  wrap_enable,
  input  logic                                  clear_state,
  input  cpar_pkg::dp_cmd_t                     cmd,
  output logic signed [cpar_pkg::IO_W-1:0]      drive,
  output logic signed [cpar_pkg::IO_W-1:0]      rate_target
);

  localparam int DW   = DATA_WIDTH;
  localparam int IOW  = cpar_pkg::IO_W;
  localparam int GW   = cpar_pkg::GAIN_W;
  localparam int SPL  = cpar_pkg::MUL_SPLIT;
  localparam int OPW  = 2 * SPL;
  localparam int MAW  = SPL + 1;
  localparam int PW   = MAW + GW;
  localparam int AW   = PW + SPL + 1;
  localparam int EW   = ((DW > IOW) ? DW : IOW) + 3;
  localparam int SW   = DW + 2;
  localparam int LW   = cpar_pkg::LIMIT_W / 2;

  // Saturation bounds of the signal range at each working width.
  localparam logic signed [EW-1:0] EMAX = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = ~EMAX;
  localparam logic signed [AW-1:0] AMAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] AMIN = ~AMAX;
  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  // Fold thresholds in fixed point.
  localparam logic signed [EW-1:0] HALF =
    EW'(64'(cpar_pkg::ANGLE_HALF_DEG) << FRAC_BITS);
  localparam logic signed [EW-1:0] FULL =
    EW'(64'(cpar_pkg::ANGLE_FULL_DEG) << FRAC_BITS);

  // Configuration.
  logic signed [GW-1:0]                  gain_r [6];
  logic [cpar_pkg::LIMIT_W-1:0]          olim_r;
  logic [cpar_pkg::LIMIT_W-1:0]          ilim_r;

  // Loop state.
  logic signed [DW-1:0]                  integ_r [2];
  logic signed [DW-1:0]                  last_r [2];

  // Working registers.
  logic signed [IOW-1:0]                 a_tgt_r, a_meas_r, r_meas_r;
  logic                                  wrap_r;
  logic signed [DW-1:0]                  err_r, deriv_r, term_r;
  logic signed [DW-1:0]                  rate_tgt_r, drive_res_r;
  logic signed [PW-1:0]                  prod_r, plo_r;
  logic signed [SW-1:0]                  sum_r;
  logic signed [IOW-1:0]                 out_drive_r, out_rate_r;

  // Combinational results.
  logic [2:0]                            gidx;
  logic signed [GW-1:0]                  gain;
  logic [cpar_pkg::LIMIT_W-1:0]          lim_sel;
  logic signed [EW-1:0]                  ilim_e, olim_e;
  logic signed [EW-1:0]                  diff;
  logic signed [DW-1:0]                  err_nxt;
  logic signed [EW-1:0]                  isum;
  logic signed [DW-1:0]                  isat;
  logic signed [EW-1:0]                  isat_e;
  logic signed [DW-1:0]                  integ_nxt;
  logic signed [EW-1:0]                  dsum;
  logic signed [DW-1:0]                  deriv_nxt;
  logic signed [DW-1:0]                  opnd;
  logic signed [OPW-1:0]                 opnd_x;
  logic signed [MAW-1:0]                 mul_a;
  logic signed [PW-1:0]                  mul_p;
  logic signed [AW-1:0]                  full_p, shf_p;
  logic signed [DW-1:0]                  term_nxt;
  logic signed [SW-1:0]                  sum_nxt;
  logic signed [DW-1:0]                  ssat;
  logic signed [EW-1:0]                  ssat_e;
  logic signed [DW-1:0]                  res_nxt;

  // Gain and limit selection for the active loop.
  always_comb begin
    if (cmd.loop == cpar_pkg::LOOP_INNER) begin
      gidx    = 3'(cpar_pkg::CFG_INNER_KP) + 3'(cmd.term);
      lim_sel = ilim_r;
    end else begin
      gidx    = 3'(cpar_pkg::CFG_OUTER_KP) + 3'(cmd.term);
      lim_sel = olim_r;
    end
    gain   = gain_r[gidx];
    ilim_e = EW'($signed(lim_sel[2*LW-1:LW]));
    olim_e = EW'($signed(lim_sel[LW-1:0]));
  end

  // Loop error: angle error with an optional single fold, or rate error.
  always_comb begin
    if (cmd.loop == cpar_pkg::LOOP_OUTER) begin
      diff = EW'(a_tgt_r) - EW'(a_meas_r);
      if (wrap_r) begin
        if (diff > HALF) begin
          diff = diff - FULL;
        end else if (diff < -HALF) begin
          diff = diff + FULL;
        end
      end
    end else begin
      diff = EW'(rate_tgt_r) - EW'(r_meas_r);
    end
    if (diff > EMAX) begin
      err_nxt = EMAX[DW-1:0];
    end else if (diff < EMIN) begin
      err_nxt = EMIN[DW-1:0];
    end else begin
      err_nxt = diff[DW-1:0];
    end
  end

  // Integral: saturating add, then symmetric clamp when the limit is positive.
  always_comb begin
    isum = EW'(integ_r[cmd.loop]) + EW'(err_r);
    if (isum > EMAX) begin
      isat = EMAX[DW-1:0];
    end else if (isum < EMIN) begin
      isat = EMIN[DW-1:0];
    end else begin
      isat = isum[DW-1:0];
    end
    isat_e    = EW'(isat);
    integ_nxt = isat;
    if (!ilim_e[EW-1] && (ilim_e != '0)) begin
      if (isat_e > ilim_e) begin
        integ_nxt = ilim_e[DW-1:0];
      end else if (isat_e < -ilim_e) begin
        integ_nxt = DW'(-ilim_e);
      end
    end
  end

  // Derivative: saturating difference against the last error.
  always_comb begin
    dsum = EW'(err_r) - EW'(last_r[cmd.loop]);
    if (dsum > EMAX) begin
      deriv_nxt = EMAX[DW-1:0];
    end else if (dsum < EMIN) begin
      deriv_nxt = EMIN[DW-1:0];
    end else begin
      deriv_nxt = dsum[DW-1:0];
    end
  end

  // Shared multiplier: low partial product (unsigned low bits), then high.
  always_comb begin
    case (cmd.term)
      cpar_pkg::TERM_P: opnd = err_r;
      cpar_pkg::TERM_I: opnd = integ_r[cmd.loop];
      cpar_pkg::TERM_D: opnd = deriv_r;
      default:          opnd = err_r;
    endcase
    opnd_x = OPW'(opnd);
    if (cmd.op == cpar_pkg::OP_MHI) begin
      mul_a = {opnd_x[OPW-1], opnd_x[OPW-1:SPL]};
    end else begin
      mul_a = {1'b0, opnd_x[SPL-1:0]};
    end
    mul_p = PW'(mul_a) * PW'(gain);
  end

  // Term: join the partial products, floor by the fraction bits, saturate.
  always_comb begin
    full_p = (AW'(prod_r) <<< SPL) + AW'(plo_r);
    shf_p  = full_p >>> FRAC_BITS;
    if (shf_p > AMAX) begin
      term_nxt = AMAX[DW-1:0];
    end else if (shf_p < AMIN) begin
      term_nxt = AMIN[DW-1:0];
    end else begin
      term_nxt = shf_p[DW-1:0];
    end
    sum_nxt = sum_r + SW'(term_r);
  end

  // Loop output: saturate the sum, then clamp when the limit is positive.
  always_comb begin
    if (sum_r > SMAX) begin
      ssat = SMAX[DW-1:0];
    end else if (sum_r < SMIN) begin
      ssat = SMIN[DW-1:0];
    end else begin
      ssat = sum_r[DW-1:0];
    end
    ssat_e  = EW'(ssat);
    res_nxt = ssat;
    if (!olim_e[EW-1] && (olim_e != '0)) begin
      if (ssat_e > olim_e) begin
        res_nxt = olim_e[DW-1:0];
      end else if (ssat_e < -olim_e) begin
        res_nxt = DW'(-olim_e);
      end
    end
  end

  // Configuration registers and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        gain_r[i] <= '0;
      end
      olim_r     <= '0;
      ilim_r     <= '0;
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      last_r[0]  <= '0;
      last_r[1]  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index) inside
          cpar_pkg::CFG_OUTER_KP, cpar_pkg::CFG_OUTER_KI, cpar_pkg::CFG_OUTER_KD,
          cpar_pkg::CFG_INNER_KP, cpar_pkg::CFG_INNER_KI, cpar_pkg::CFG_INNER_KD: begin
            gain_r[cfg_index] <= cfg_wr_data[GW-1:0];
          end
          cpar_pkg::CFG_OUTER_LIMITS: olim_r <= cfg_wr_data;
          cpar_pkg::CFG_INNER_LIMITS: ilim_r <= cfg_wr_data;
          default: ;
        endcase
      end
      if ((cmd.op == cpar_pkg::OP_LOAD) && clear_state) begin
        integ_r[0] <= '0;
        integ_r[1] <= '0;
        last_r[0]  <= '0;
        last_r[1]  <= '0;
      end else if (cmd.op == cpar_pkg::OP_INT) begin
        integ_r[cmd.loop] <= integ_nxt;
        last_r[cmd.loop]  <= err_r;
      end
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cpar_pkg::OP_LOAD: begin
        a_tgt_r  <= angle_setpoint;
        a_meas_r <= angle_measured;
        r_meas_r <= rate_measured;
        wrap_r   <= wrap_enable;
      end
      cpar_pkg::OP_ERR: err_r <= err_nxt;
      cpar_pkg::OP_INT: begin
        deriv_r <= deriv_nxt;
        sum_r   <= '0;
      end
      cpar_pkg::OP_MLO: prod_r <= mul_p;
      cpar_pkg::OP_MHI: begin
        plo_r  <= prod_r;
        prod_r <= mul_p;
      end
      cpar_pkg::OP_TERM: term_r <= term_nxt;
      cpar_pkg::OP_ACC:  sum_r  <= sum_nxt;
      cpar_pkg::OP_FIN: begin
        if (cmd.loop == cpar_pkg::LOOP_OUTER) begin
          rate_tgt_r <= res_nxt;
        end else begin
          drive_res_r <= res_nxt;
        end
      end
      cpar_pkg::OP_PUSH: begin
        out_drive_r <= IOW'(drive_res_r);
        out_rate_r  <= IOW'(rate_tgt_r);
      end
      default: ;
    endcase
  end

  assign drive       = out_drive_r;
  assign rate_target = out_rate_r;

endmodule

// ----- design/cascade_pid_angle_rate_top.sv -----
// ----------------------------------------------------------------------------
// cascade_pid_angle_rate_top
// Two-loop angle/rate PID for one axis, one control tick per input beat.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  in_      slave      tdata: angle_setpoint, angle_measured, rate_measured
//                      tuser: wrap_enable, clear_state
//  out_     master     tdata: drive, rate_target
//  cfg_     write      index 0..7: six gains, outer and inner limits
//
//  Each item is accepted, then each loop runs error, integral and derivative,
//  then three gain terms on the one shared 25x24 multiplier (low and high
//  partial products, term, accumulate), then the output clamp; last the result
//  is loaded. rst_n is synchronous and clears the configuration, loop state
//  and handshakes. The result register holds a finished beat, so the next
//  input is taken while it waits; the sequencer only pauses when the previous
//  result has still not been taken.
//
`timescale 1ns / 1ps

module cascade_pid_angle_rate_top #(
  parameter int DATA_WIDTH = cpar_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cpar_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: angle_setpoint [31:0], angle_measured [63:32], rate_measured [95:64]
  input  logic [cpar_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: wrap_enable [0], clear_state [1]
  input  logic [cpar_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: drive [31:0], rate_target [63:32]
  output logic [cpar_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [cpar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpar_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  localparam int IOW = cpar_pkg::IO_W;

  cpar_pkg::dp_cmd_t       cmd;
  logic signed [IOW-1:0]   angle_setpoint, angle_measured, rate_measured;
  logic                    wrap_enable, clear_state;
  logic signed [IOW-1:0]   drive, rate_target;

  // Unpack the input beat.
  assign angle_setpoint = in_tdata[IOW-1:0];
  assign angle_measured = in_tdata[2*IOW-1:IOW];
  assign rate_measured  = in_tdata[3*IOW-1:2*IOW];
  assign wrap_enable    = in_tuser[0];
  assign clear_state    = in_tuser[1];

  // Pack the result beat.
  assign out_tdata = {rate_target, drive};

  cpar_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cpar_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .angle_setpoint (angle_setpoint),
    .angle_measured (angle_measured),
    .rate_measured  (rate_measured),
    .wrap_enable    (wrap_enable),
    .clear_state    (clear_state),
    .cmd            (cmd),
    .drive          (drive),
    .rate_target    (rate_target)
  );

endmodule

// ----- design/cpar_checker.sv -----
// ----------------------------------------------------------------------------
// cpar_checker
// Port-level checks of the cascade PID, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpar_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [cpar_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready
);

  // A stalled result beat stays and holds its payload.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat dropped or changed while stalled")

  // One tick is worked at a time: the input closes right after a beat.
  `ASSERT_CLK(a_in_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input still open after accepting a beat")

  // A new result only appears at the end of a tick, never while idle.
  `ASSERT_CLK(a_out_from_work, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready), "result raised while the block was idle")

  // Reset leaves no result pending and the input open.
  `ASSERT_CLK_NORST(a_reset_state, clk, !rst_n |=> !out_tvalid && in_tready, "bad handshake state after reset")

endmodule

bind cascade_pid_angle_rate_top cpar_checker u_cpar_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cascade angle/rate PID. Every accepted input
// beat runs through a local fixed-point model of both loops, and each output
// beat is checked field by field against the oldest pending prediction.
// Gains and limits change between phases while the block is idle, and both
// stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cpar_pkg::*;

  localparam int          FRAC        = FRAC_BITS_DEF;
  localparam longint      SIG_MAX     = 64'sd2147483647;
  localparam longint      SIG_MIN     = -64'sd2147483648;
  localparam longint      HALF_TURN   = longint'(ANGLE_HALF_DEG) <<< FRAC;
  localparam longint      FULL_TURN   = longint'(ANGLE_FULL_DEG) <<< FRAC;
  localparam int unsigned ANGLE_SPAN  = ANGLE_HALF_DEG << FRAC;
  localparam int unsigned RATE_SPAN   = 500 << FRAC;
  localparam int unsigned TRACK_NOISE = 20 << FRAC;
  localparam int          PHASE_TICKS = 225;
  localparam int          CYCLE_LIMIT = 800000;

  // Expected contents of one output beat.
  typedef struct {
    logic [IO_W-1:0] drive;
    logic [IO_W-1:0] rate_target;
  } pid_out_t;

  // Scoreboard: a copy of the configuration and loop state, plus the queue
  // of predicted output beats.
  class pid_scoreboard;
    logic [CFG_DATA_W-1:0] regs [8];
    longint                integ [2];
    longint                last_err [2];
    pid_out_t              expected_q [$];
    int                    errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (integ[i]) begin
        integ[i]    = 0;
        last_err[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      regs[int'(idx)] = val;
    endfunction

    function longint sat32(longint v);
      if (v > SIG_MAX) return SIG_MAX;
      if (v < SIG_MIN) return SIG_MIN;
      return v;
    endfunction

    // Gain product, floored after the fraction shift, then saturated.
    function longint scale(longint a, logic [GAIN_W-1:0] g);
      longint gs;
      gs = $signed(g);
      return sat32((a * gs) >>> FRAC);
    endfunction

    // Symmetric clamp; a limit of zero or below leaves the value alone.
    function longint clamp_sym(longint v, logic [IO_W-1:0] lim_bits);
      longint lim;
      lim = $signed(lim_bits);
      if (lim <= 0) return v;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint loop_tick(loop_t lp, longint err, cfg_reg_t kp_idx,
                               cfg_reg_t ki_idx, cfg_reg_t kd_idx,
                               cfg_reg_t lim_idx);
      longint deriv;
      longint acc;
      logic [LIMIT_W-1:0] lims;
      lims = regs[int'(lim_idx)];
      integ[int'(lp)] = clamp_sym(sat32(integ[int'(lp)] + err), lims[63:32]);
      deriv = sat32(err - last_err[int'(lp)]);
      acc = scale(err, regs[int'(kp_idx)][GAIN_W-1:0])
          + scale(integ[int'(lp)], regs[int'(ki_idx)][GAIN_W-1:0])
          + scale(deriv, regs[int'(kd_idx)][GAIN_W-1:0]);
      acc = clamp_sym(sat32(acc), lims[31:0]);
      last_err[int'(lp)] = err;
      return acc;
    endfunction

    // One control tick: predict both outputs for an accepted input beat.
    function void note_tick(logic [IN_TDATA_W-1:0] data,
                            logic [IN_TUSER_W-1:0] user);
      longint   tgt;
      longint   meas;
      longint   rate;
      longint   err;
      longint   rt;
      longint   drv;
      pid_out_t e;
      tgt  = $signed(data[31:0]);
      meas = $signed(data[63:32]);
      rate = $signed(data[95:64]);
      if (user[1]) begin
        foreach (integ[i]) begin
          integ[i]    = 0;
          last_err[i] = 0;
        end
      end
      err = tgt - meas;
      // The fold by one full turn is applied once only.
      if (user[0]) begin
        if (err > HALF_TURN) err -= FULL_TURN;
        else if (err < -HALF_TURN) err += FULL_TURN;
      end
      err = sat32(err);
      rt = loop_tick(LOOP_OUTER, err, CFG_OUTER_KP, CFG_OUTER_KI, CFG_OUTER_KD,
                     CFG_OUTER_LIMITS);
      err = sat32(rt - rate);
      drv = loop_tick(LOOP_INNER, err, CFG_INNER_KP, CFG_INNER_KI, CFG_INNER_KD,
                      CFG_INNER_LIMITS);
      e.drive       = drv[31:0];
      e.rate_target = rt[31:0];
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data);
      pid_out_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("output beat %h with no tick pending", data));
      end else begin
        e = expected_q.pop_front();
        if (data[31:0] !== e.drive)
          report($sformatf("drive %h, expected %h", data[31:0], e.drive));
        if (data[63:32] !== e.rate_target)
          report($sformatf("rate_target %h, expected %h", data[63:32],
                           e.rate_target));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;
  logic                   in_calm;
  logic                   out_calm;
  int                     cycles = 0;
  pid_scoreboard          sb = new();

  cascade_pid_angle_rate_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Beat monitors on both stream sides.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_tick(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side: a random stall before each beat is taken.
  initial begin
    int stall;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pad_gain(logic [GAIN_W-1:0] g);
    // Upper bits are junk that the block must ignore.
    return {$urandom(), 8'($urandom()), g};
  endfunction

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 7))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return '0;
      3, 4: return 24'($urandom());
      default: return 24'($urandom_range(0, 1 << 19) - (1 << 18));
    endcase
  endfunction

  function automatic logic [IO_W-1:0] draw_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {1'b1, 31'($urandom())};
      2: return 32'h7FFF_FFFF;
      3: return 32'd1;
      4, 5: return $urandom_range(1, 400 << FRAC);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IO_W-1:0] draw_signal(int unsigned span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return span;
          default: return -span;
        endcase
      end
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic program_set(logic [GAIN_W-1:0] okp, oki, okd, ikp, iki, ikd,
                             logic [LIMIT_W-1:0] olim, ilim);
    write_reg(CFG_OUTER_KP, pad_gain(okp));
    write_reg(CFG_OUTER_KI, pad_gain(oki));
    write_reg(CFG_OUTER_KD, pad_gain(okd));
    write_reg(CFG_INNER_KP, pad_gain(ikp));
    write_reg(CFG_INNER_KI, pad_gain(iki));
    write_reg(CFG_INNER_KD, pad_gain(ikd));
    write_reg(CFG_OUTER_LIMITS, olim);
    write_reg(CFG_INNER_LIMITS, ilim);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one tick; called at a falling edge and returns at one.
  task automatic send_tick(logic [IO_W-1:0] tgt, meas, rate, logic wrap, clr);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {rate, meas, tgt};
    in_tuser  <= {clr, wrap};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Waits until every predicted beat has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Edge cases: saturation, fold boundaries, folds that stay out of range,
  // floor rounding of small negative errors, and clears with live state.
  task automatic run_directed();
    logic [IO_W-1:0] h;
    h = ANGLE_SPAN;
    send_tick('0, '0, '0, 1'b0, 1'b1);
    send_tick(h, '0, '0, 1'b1, 1'b0);
    send_tick('0, h, '0, 1'b1, 1'b0);
    send_tick(h + 1, '0, '0, 1'b1, 1'b0);
    send_tick('0, h + 1, '0, 1'b1, 1'b0);
    send_tick(h + 1, '0, '0, 1'b0, 1'b0);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b0, 1'b0);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b1, 1'b0);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b1, 1'b0);
    send_tick(3 * h + 5, '0, '0, 1'b1, 1'b0);
    send_tick('0, 3 * h + 5, '0, 1'b1, 1'b0);
    send_tick('0, '0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_tick('0, '0, 32'h8000_0000, 1'b0, 1'b0);
    send_tick(-h, h, '0, 1'b1, 1'b0);
    send_tick(h, -h, '0, 1'b1, 1'b0);
    send_tick(32'hFFFF_FFFF, '0, 32'd1, 1'b0, 1'b0);
    send_tick('0, 32'd3, 32'hFFFF_FFFD, 1'b1, 1'b0);
    repeat (4) send_tick(h >> 1, '0, 32'h0010_0000, 1'b1, 1'b0);
    send_tick(h >> 1, '0, '0, 1'b1, 1'b1);
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
  endtask

  // Tracking runs: the target holds for a while and the measurement follows
  // it closely, with some wild measurements and rare clears mixed in.
  task automatic run_random(int count);
    logic [IO_W-1:0] tgt;
    logic [IO_W-1:0] meas;
    tgt = draw_signal(ANGLE_SPAN);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 23) == 0) tgt = draw_signal(ANGLE_SPAN);
      if ($urandom_range(0, 9) < 3) meas = draw_signal(ANGLE_SPAN);
      else meas = tgt + ($urandom_range(0, 2 * TRACK_NOISE) - TRACK_NOISE);
      send_tick(tgt, meas, draw_signal(RATE_SPAN), 1'($urandom_range(0, 1)),
                $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_OUTER_KP;
    cfg_wr_data = '0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Moderate gains with active clamps for the edge cases.
    program_set(24'h02_0000, 24'h00_8000, 24'hFF_C000,
                24'h01_8000, 24'h00_4000, 24'h00_1000,
                {32'(100 << FRAC), 32'(200 << FRAC)},
                {32'(50 << FRAC), 32'(1000 << FRAC)});
    run_directed();
    run_random(PHASE_TICKS);
    drain();

    // Largest gains with every clamp disabled.
    in_calm  = 1'b1;
    program_set(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
                24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, '0, '0);
    run_random(PHASE_TICKS);
    drain();

    // Most negative gains with the widest limits.
    in_calm  = 1'b0;
    out_calm = 1'b1;
    program_set(24'h80_0000, 24'h80_0000, 24'h80_0000,
                24'h80_0000, 24'h80_0000, 24'h80_0000,
                {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
    run_random(PHASE_TICKS);
    drain();

    for (int p = 0; p < 5; p++) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      program_set(draw_gain(), draw_gain(), draw_gain(),
                  draw_gain(), draw_gain(), draw_gain(),
                  {draw_limit(), draw_limit()}, {draw_limit(), draw_limit()});
      run_random(PHASE_TICKS);
      drain();
    end

    // Catch any stray beats after the last expected one.
    repeat (48) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/cpar_pkg.sv
design/cpar_ctrl.sv
design/cpar_datapath.sv
design/cascade_pid_angle_rate_top.sv
design/cpar_checker.sv
tb/sv/tb_top.sv
